// ===== src/dwe_pkg.sv =====
package dwe_pkg;

    // encoder counter width, 16 to 32
    localparam int COUNT_WIDTH = 32;

    localparam int POS_W  = 32;
    localparam int RATE_W = 24;
    localparam int ERR_W  = 25;
    localparam int ACC_W  = 17;
    localparam int GOAL_W = 18;
    localparam int GAIN_W = 16;
    localparam int CMP_W  = 16;
    localparam int DUTY_W = 16;
    localparam int CFG_W  = 18;
    localparam int POL_W  = 4;

    localparam int MUL_A_W = (COUNT_WIDTH > ERR_W) ? COUNT_WIDTH : ERR_W;
    localparam int MUL_B_W = GAIN_W + 1;
    localparam int PROD_W  = MUL_A_W + MUL_B_W;

    localparam int RATE_SHIFT = 8;
    localparam int GAIN_SHIFT = 16;
    localparam int DUTY_SHIFT = 15;

    localparam logic signed [PROD_W-1:0] RATE_HI = PROD_W'(8388607);
    localparam logic signed [PROD_W-1:0] RATE_LO = PROD_W'(-8388608);
    localparam logic signed [PROD_W-1:0] ACC_HI  = PROD_W'(22938);
    localparam logic signed [PROD_W-1:0] ACC_LO  = PROD_W'(-6554);
    localparam logic [GOAL_W-1:0]        ONE_RPM = GOAL_W'(16);
    localparam logic [DUTY_W-1:0]        FULL_DUTY = DUTY_W'(32768);

    // operations
    localparam logic [2:0] OP_EDGE_RIGHT = 3'd0;
    localparam logic [2:0] OP_EDGE_LEFT  = 3'd1;
    localparam logic [2:0] OP_TICK       = 3'd2;
    localparam logic [2:0] OP_SET        = 3'd3;
    localparam logic [2:0] OP_PREPARE    = 3'd4;
    localparam logic [2:0] OP_COAST      = 3'd5;
    localparam logic [2:0] OP_BRAKE      = 3'd6;

    // configuration register indexes
    localparam logic [2:0] REG_PROP_GAIN     = 3'd0;
    localparam logic [2:0] REG_INT_GAIN_DT   = 3'd1;
    localparam logic [2:0] REG_START_DUTY    = 3'd2;
    localparam logic [2:0] REG_MAX_DUTY      = 3'd3;
    localparam logic [2:0] REG_RPM_PER_COUNT = 3'd4;
    localparam logic [2:0] REG_MAX_RPM       = 3'd5;
    localparam logic [2:0] REG_PWM_PERIOD    = 3'd6;
    localparam logic [2:0] REG_POLARITY      = 3'd7;

    // sequencer steps
    localparam int STEP_W = 4;
    localparam logic [STEP_W-1:0] ST_IDLE     = 4'd0;
    localparam logic [STEP_W-1:0] ST_MUL_RATE = 4'd1;
    localparam logic [STEP_W-1:0] ST_SAT_RATE = 4'd2;
    localparam logic [STEP_W-1:0] ST_MUL_INT  = 4'd3;
    localparam logic [STEP_W-1:0] ST_ACC      = 4'd4;
    localparam logic [STEP_W-1:0] ST_DUTY     = 4'd5;
    localparam logic [STEP_W-1:0] ST_MUL_CMP  = 4'd6;
    localparam logic [STEP_W-1:0] ST_WRITE    = 4'd7;
    localparam logic [STEP_W-1:0] ST_FINISH   = 4'd8;

    typedef struct packed {
        logic [2:0]        operation;
        logic              phase_a;
        logic              phase_b;
        logic [GOAL_W-1:0] target_right;
        logic [GOAL_W-1:0] target_left;
    } cmd_t;

    typedef struct packed {
        logic [CMP_W-1:0]         right_compare;
        logic [CMP_W-1:0]         left_compare;
        logic                     right_in1;
        logic                     right_in2;
        logic                     left_in1;
        logic                     left_in2;
        logic signed [RATE_W-1:0] speed_right;
        logic signed [RATE_W-1:0] speed_left;
        logic signed [POS_W-1:0]  position_right;
        logic signed [POS_W-1:0]  position_left;
    } res_t;

    typedef struct packed {
        logic start_tick;
        logic start_other;
        logic goal_low;
        logic res_free;
    } seq_stat_t;

    typedef struct packed {
        logic              ready;
        logic [STEP_W-1:0] step;
        logic              wheel;
    } seq_ctl_t;

endpackage

// ===== src/dwe_mul.sv =====
module dwe_mul
    import dwe_pkg::*;
(
    input  logic                      clk,
    input  logic signed [MUL_A_W-1:0] a,
    input  logic signed [MUL_B_W-1:0] b,
    output logic signed [PROD_W-1:0]  prod
);

    logic signed [PROD_W-1:0] prod_reg;

    // product is registered and appears in the cycle after its operands
    always_ff @(posedge clk)
    begin
        prod_reg <= PROD_W'(a) * PROD_W'(b);
    end

    assign prod = prod_reg;

endmodule

// ===== src/dwe_seq.sv =====
module dwe_seq
    import dwe_pkg::*;
(
    input  logic      clk,
    input  logic      rst_n,
    input  seq_stat_t stat,
    output seq_ctl_t  ctl
);

    logic [STEP_W-1:0] step_reg;
    logic [STEP_W-1:0] step_next;
    logic              wheel_reg;
    logic              wheel_next;

    always_comb
    begin
        step_next  = step_reg;
        wheel_next = wheel_reg;
        case (step_reg)
            ST_IDLE:
            begin
                if (stat.start_tick)
                begin
                    step_next  = ST_MUL_RATE;
                    wheel_next = 1'b0;
                end
                else if (stat.start_other)
                begin
                    step_next = ST_FINISH;
                end
            end
            ST_MUL_RATE: step_next = ST_SAT_RATE;
            ST_SAT_RATE:
            begin
                if (!stat.goal_low)
                begin
                    step_next = ST_MUL_INT;
                end
                else if (!wheel_reg)
                begin
                    step_next  = ST_MUL_RATE;
                    wheel_next = 1'b1;
                end
                else
                begin
                    step_next = ST_FINISH;
                end
            end
            ST_MUL_INT:  step_next = ST_ACC;
            ST_ACC:      step_next = ST_DUTY;
            ST_DUTY:     step_next = ST_MUL_CMP;
            ST_MUL_CMP:  step_next = ST_WRITE;
            ST_WRITE:
            begin
                if (!wheel_reg)
                begin
                    step_next  = ST_MUL_RATE;
                    wheel_next = 1'b1;
                end
                else
                begin
                    step_next = ST_FINISH;
                end
            end
            ST_FINISH:
            begin
                if (stat.res_free)
                begin
                    step_next = ST_IDLE;
                end
            end
            default: step_next = ST_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            step_reg  <= ST_IDLE;
            wheel_reg <= 1'b0;
        end
        else
        begin
            step_reg  <= step_next;
            wheel_reg <= wheel_next;
        end
    end

    assign ctl.ready = (step_reg == ST_IDLE);
    assign ctl.step  = step_reg;
    assign ctl.wheel = wheel_reg;

endmodule

// ===== src/dual_wheel_encoder_pi_speed_loop.sv =====
// channel   | signals                          | direction | word
// ----------+----------------------------------+-----------+-----------------------------
// command   | cmd_valid cmd_ready cmd_word     | in        | cmd_t: operation, phases, targets
// result    | res_valid res_ready res_word     | out       | res_t: compares, pins, speeds, counts
// config    | cfg_valid cfg_ready cfg_index    | in        | register index 0..7, cfg_data
//           | cfg_data                         |           |
//
// one command word at a time; cmd_ready is high only while the sequencer is idle
// a control tick runs per wheel the rate multiply and saturate steps, then unless the
// target is below 1 rpm the integral, accumulate, duty, compare and write steps, as the
// single shared multiplier is used four times per wheel; every other operation goes to finish
// the result word sits in an output register, so a stalled res_ready holds only the finish
// step; rst_n clears all but the working registers and result word; cfg_ready is always high

module dual_wheel_encoder_pi_speed_loop
    import dwe_pkg::*;
(
    input  logic             clk,
    input  logic             rst_n,
    input  logic             cmd_valid,
    output logic             cmd_ready,
    input  cmd_t             cmd_word,
    output logic             res_valid,
    input  logic             res_ready,
    output res_t             res_word,
    input  logic             cfg_valid,
    output logic             cfg_ready,
    input  logic [2:0]       cfg_index,
    input  logic [CFG_W-1:0] cfg_data
);

    // configuration registers
    logic [GAIN_W-1:0] prop_gain_reg;
    logic [GAIN_W-1:0] int_gain_reg;
    logic [DUTY_W-1:0] start_duty_reg;
    logic [DUTY_W-1:0] max_duty_reg;
    logic [GAIN_W-1:0] rpm_per_count_reg;
    logic [GOAL_W-1:0] max_rpm_reg;
    logic [CMP_W-1:0]  pwm_period_reg;
    logic [POL_W-1:0]  polarity_reg;

    // per wheel state, index 0 right, 1 left
    logic [COUNT_WIDTH-1:0]   count_reg [2];
    logic [COUNT_WIDTH-1:0]   prior_reg [2];
    logic signed [ACC_W-1:0]  accum_reg [2];
    logic [GOAL_W-1:0]        goal_reg  [2];
    logic signed [RATE_W-1:0] rate_reg  [2];
    logic [CMP_W-1:0]         cmp_reg   [2];
    // right in1, right in2, left in1, left in2 from bit 0 up
    logic [3:0]               pins_reg;

    // working registers of the loop step
    logic signed [ERR_W-1:0] err_reg;
    logic [DUTY_W-1:0]       duty_reg;

    logic res_valid_reg;
    res_t res_word_reg;

    seq_stat_t stat;
    seq_ctl_t  ctl;

    logic cmd_fire;
    logic w;

    // shared multiplier operands and product
    logic signed [MUL_A_W-1:0] mul_a;
    logic signed [MUL_B_W-1:0] mul_b;
    logic signed [PROD_W-1:0]  prod;

    logic [COUNT_WIDTH-1:0]   delta;
    logic signed [PROD_W-1:0] rate_shift;
    logic signed [RATE_W-1:0] rate_sat;
    logic signed [ERR_W-1:0]  err_new;
    logic signed [PROD_W-1:0] gain_shift;
    logic signed [PROD_W-1:0] acc_sum;
    logic signed [ACC_W-1:0]  acc_clamp;
    logic signed [PROD_W-1:0] duty_sum;
    logic [DUTY_W-1:0]        duty_lim;
    logic [DUTY_W-1:0]        duty_clamp;
    logic                     goal_low;
    logic                     edge_eq;

    assign cmd_fire  = cmd_valid && cmd_ready;
    assign cmd_ready = ctl.ready;
    assign cfg_ready = 1'b1;
    assign w         = ctl.wheel;

    assign goal_low = (goal_reg[w] < ONE_RPM);
    assign edge_eq  = (cmd_word.phase_a == cmd_word.phase_b);

    assign stat.start_tick  = cmd_fire && (cmd_word.operation == OP_TICK);
    assign stat.start_other = cmd_fire && (cmd_word.operation != OP_TICK);
    assign stat.goal_low    = goal_low;
    assign stat.res_free    = !res_valid_reg || res_ready;

    dwe_seq u_seq (
        .clk   (clk),
        .rst_n (rst_n),
        .stat  (stat),
        .ctl   (ctl)
    );

    // operand select: rate, integral, proportional, then compare scaling
    always_comb
    begin
        mul_a = '0;
        mul_b = '0;
        case (ctl.step)
            ST_MUL_RATE:
            begin
                mul_a = MUL_A_W'($signed(delta));
                mul_b = $signed({1'b0, rpm_per_count_reg});
            end
            ST_MUL_INT:
            begin
                mul_a = MUL_A_W'(err_reg);
                mul_b = $signed({1'b0, int_gain_reg});
            end
            ST_ACC:
            begin
                mul_a = MUL_A_W'(err_reg);
                mul_b = $signed({1'b0, prop_gain_reg});
            end
            ST_MUL_CMP:
            begin
                mul_a = MUL_A_W'($signed({1'b0, duty_reg}));
                mul_b = $signed({1'b0, pwm_period_reg});
            end
            default:
            begin
                mul_a = '0;
                mul_b = '0;
            end
        endcase
    end

    dwe_mul u_mul (
        .clk  (clk),
        .a    (mul_a),
        .b    (mul_b),
        .prod (prod)
    );

    // count change since the last tick, wraps at the counter width
    assign delta = count_reg[w] - prior_reg[w];

    // speed: floor of product over 256, saturated to 24 bits
    always_comb
    begin
        rate_shift = prod >>> RATE_SHIFT;
        if (rate_shift > RATE_HI)
        begin
            rate_sat = RATE_HI[RATE_W-1:0];
        end
        else if (rate_shift < RATE_LO)
        begin
            rate_sat = RATE_LO[RATE_W-1:0];
        end
        else
        begin
            rate_sat = rate_shift[RATE_W-1:0];
        end
        err_new = $signed({{(ERR_W-GOAL_W){1'b0}}, goal_reg[w]}) - ERR_W'(rate_sat);
    end

    assign gain_shift = prod >>> GAIN_SHIFT;

    // integrator update with anti-windup clamp
    always_comb
    begin
        acc_sum = PROD_W'(accum_reg[w]) + gain_shift;
        if (acc_sum > ACC_HI)
        begin
            acc_clamp = ACC_HI[ACC_W-1:0];
        end
        else if (acc_sum < ACC_LO)
        begin
            acc_clamp = ACC_LO[ACC_W-1:0];
        end
        else
        begin
            acc_clamp = acc_sum[ACC_W-1:0];
        end
    end

    // duty = feedforward + proportional + integral, clamped to [0, limit]
    always_comb
    begin
        duty_lim = (max_duty_reg > FULL_DUTY) ? FULL_DUTY : max_duty_reg;
        duty_sum = PROD_W'($signed({1'b0, start_duty_reg})) + gain_shift
                   + PROD_W'(accum_reg[w]);
        if (duty_sum < 0)
        begin
            duty_clamp = '0;
        end
        else if (duty_sum > PROD_W'($signed({1'b0, duty_lim})))
        begin
            duty_clamp = duty_lim;
        end
        else
        begin
            duty_clamp = duty_sum[DUTY_W-1:0];
        end
    end

    // working registers, no reset needed
    always_ff @(posedge clk)
    begin
        if (ctl.step == ST_SAT_RATE)
        begin
            err_reg <= err_new;
        end
        if (ctl.step == ST_DUTY)
        begin
            duty_reg <= duty_clamp;
        end
        if (ctl.step == ST_FINISH && stat.res_free)
        begin
            res_word_reg.right_compare  <= cmp_reg[0];
            res_word_reg.left_compare   <= cmp_reg[1];
            res_word_reg.right_in1      <= pins_reg[0];
            res_word_reg.right_in2      <= pins_reg[1];
            res_word_reg.left_in1       <= pins_reg[2];
            res_word_reg.left_in2       <= pins_reg[3];
            res_word_reg.speed_right    <= rate_reg[0];
            res_word_reg.speed_left     <= rate_reg[1];
            res_word_reg.position_right <= POS_W'($signed(count_reg[0]));
            res_word_reg.position_left  <= POS_W'($signed(count_reg[1]));
        end
    end

    // state and configuration
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            prop_gain_reg     <= '0;
            int_gain_reg      <= '0;
            start_duty_reg    <= '0;
            max_duty_reg      <= FULL_DUTY;
            rpm_per_count_reg <= '0;
            max_rpm_reg       <= '0;
            pwm_period_reg    <= CMP_W'(1000);
            polarity_reg      <= '0;
            for (int i = 0; i < 2; i++)
            begin
                count_reg[i] <= '0;
                prior_reg[i] <= '0;
                accum_reg[i] <= '0;
                goal_reg[i]  <= '0;
                rate_reg[i]  <= '0;
                cmp_reg[i]   <= '0;
            end
            pins_reg      <= '0;
            res_valid_reg <= 1'b0;
        end
        else
        begin
            if (cfg_valid && cfg_ready)
            begin
                case (cfg_index)
                    REG_PROP_GAIN:     prop_gain_reg     <= cfg_data[GAIN_W-1:0];
                    REG_INT_GAIN_DT:   int_gain_reg      <= cfg_data[GAIN_W-1:0];
                    REG_START_DUTY:    start_duty_reg    <= cfg_data[DUTY_W-1:0];
                    REG_MAX_DUTY:      max_duty_reg      <= cfg_data[DUTY_W-1:0];
                    REG_RPM_PER_COUNT: rpm_per_count_reg <= cfg_data[GAIN_W-1:0];
                    REG_MAX_RPM:       max_rpm_reg       <= cfg_data[GOAL_W-1:0];
                    REG_PWM_PERIOD:    pwm_period_reg    <= cfg_data[CMP_W-1:0];
                    REG_POLARITY:      polarity_reg      <= cfg_data[POL_W-1:0];
                    default: ;
                endcase
            end

            // operations take effect at acceptance; a tick also sets its forward pins here
            if (cmd_fire)
            begin
                case (cmd_word.operation)
                    OP_EDGE_RIGHT:
                    begin
                        count_reg[0] <= (edge_eq == polarity_reg[0])
                                        ? count_reg[0] + 1'b1 : count_reg[0] - 1'b1;
                    end
                    OP_EDGE_LEFT:
                    begin
                        count_reg[1] <= (edge_eq == polarity_reg[1])
                                        ? count_reg[1] + 1'b1 : count_reg[1] - 1'b1;
                    end
                    OP_TICK:
                    begin
                        // forward direction per wheel
                        pins_reg <= {!polarity_reg[3], polarity_reg[3],
                                     !polarity_reg[2], polarity_reg[2]};
                    end
                    OP_SET:
                    begin
                        goal_reg[0] <= (cmd_word.target_right > max_rpm_reg)
                                       ? max_rpm_reg : cmd_word.target_right;
                        goal_reg[1] <= (cmd_word.target_left > max_rpm_reg)
                                       ? max_rpm_reg : cmd_word.target_left;
                    end
                    OP_PREPARE:
                    begin
                        prior_reg[0] <= count_reg[0];
                        prior_reg[1] <= count_reg[1];
                        accum_reg[0] <= '0;
                        accum_reg[1] <= '0;
                        rate_reg[0]  <= '0;
                        rate_reg[1]  <= '0;
                    end
                    OP_COAST:
                    begin
                        goal_reg[0]  <= '0;
                        goal_reg[1]  <= '0;
                        accum_reg[0] <= '0;
                        accum_reg[1] <= '0;
                        cmp_reg[0]   <= '0;
                        cmp_reg[1]   <= '0;
                        pins_reg     <= '0;
                    end
                    OP_BRAKE:
                    begin
                        goal_reg[0]  <= '0;
                        goal_reg[1]  <= '0;
                        accum_reg[0] <= '0;
                        accum_reg[1] <= '0;
                        cmp_reg[0]   <= pwm_period_reg;
                        cmp_reg[1]   <= pwm_period_reg;
                        pins_reg     <= '1;
                    end
                    default: ;
                endcase
            end

            // tick sequence for the wheel under work
            case (ctl.step)
                ST_SAT_RATE:
                begin
                    rate_reg[w]  <= rate_sat;
                    prior_reg[w] <= count_reg[w];
                    if (goal_low)
                    begin
                        // below 1 rpm: integrator cleared, motor off
                        accum_reg[w] <= '0;
                        cmp_reg[w]   <= '0;
                    end
                end
                ST_ACC:
                begin
                    accum_reg[w] <= acc_clamp;
                end
                ST_WRITE:
                begin
                    cmp_reg[w] <= prod[DUTY_SHIFT+CMP_W-1:DUTY_SHIFT];
                end
                default: ;
            endcase

            // output register
            if (ctl.step == ST_FINISH && stat.res_free)
            begin
                res_valid_reg <= 1'b1;
            end
            else if (res_ready)
            begin
                res_valid_reg <= 1'b0;
            end
        end
    end

    assign res_valid = res_valid_reg;
    assign res_word  = res_word_reg;

    // integrators stay inside their clamp window
    assert property (@(posedge clk) disable iff (!rst_n)
        accum_reg[0] >= -6554 && accum_reg[0] <= 22938 &&
        accum_reg[1] >= -6554 && accum_reg[1] <= 22938)
    else $error("integrator outside clamp window");

    // scaled duty never exceeds full scale
    assert property (@(posedge clk) disable iff (!rst_n)
        ctl.step == ST_MUL_CMP |-> duty_reg <= FULL_DUTY)
    else $error("duty above full scale");

    // an accepted tick starts with the right wheel rate product
    assert property (@(posedge clk) disable iff (!rst_n)
        cmd_fire && cmd_word.operation == OP_TICK |=>
        ctl.step == ST_MUL_RATE && !ctl.wheel)
    else $error("tick did not start on the right wheel");

    // coast drops both compares and all pins
    assert property (@(posedge clk) disable iff (!rst_n)
        cmd_fire && cmd_word.operation == OP_COAST |=>
        cmp_reg[0] == '0 && cmp_reg[1] == '0 && pins_reg == '0)
    else $error("coast left the drive active");

endmodule
